// ----- hdl/dfsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dfsm_pkg
// Shared types for the first-match substring delete block: the controller
// state encoding and the command and status words between the two halves.
// ----------------------------------------------------------------------------
package dfsm_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SRD,
        ST_SCMP,
        ST_ERD,
        ST_EOUT,
        ST_EMPTY
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take the input word into a store
        logic check;      // clear search and emit counters
        logic srch_rd;    // read text[i+j] and pattern[j]
        logic hit;        // record a match at position i
        logic next_j;     // advance inside the pattern
        logic next_i;     // move to the next start position
        logic emit_rd;    // read text[k] and advance k
        logic skip;       // jump k over the matched span
        logic emit_out;   // count one delivered result
        logic finish;     // close both strings, clear overflow
        logic out_empty;  // present the empty-text result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic no_search;  // pattern empty or longer than the text
        logic cmp_eq;     // the two read characters agree
        logic pat_end;    // j is the last pattern index
        logic last_pos;   // no start position remains after i
        logic emit_empty; // the result text holds no character
        logic skip_here;  // k sits at the start of the match
        logic emit_last;  // the result being delivered is the final one
    } t_dp_status;

endpackage

// ----- hdl/dfsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// dfsm_ctrl
// Controller state machine: loads words, steps the naive search and then
// sequences the emission of the result text.
// ----------------------------------------------------------------------------
module dfsm_ctrl
    import dfsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       i_req_type,
    input  logic       i_last_char,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       busy,
    output logic       o_valid,
    output logic       o_out_present,
    output logic       o_out_last
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = start && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_req_type && i_last_char) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_status.no_search ? ST_ERD : ST_SRD;
            end
            ST_SRD: begin
                n_state = ST_SCMP;
            end
            ST_SCMP: begin
                if (i_status.cmp_eq && i_status.pat_end) begin
                    n_state = ST_ERD;
                end else if (i_status.cmp_eq) begin
                    n_state = ST_SRD;
                end else if (i_status.last_pos) begin
                    n_state = ST_ERD;
                end else begin
                    n_state = ST_SRD;
                end
            end
            ST_ERD: begin
                if (i_status.emit_empty) begin
                    n_state = ST_EMPTY;
                end else if (!i_status.skip_here) begin
                    n_state = ST_EOUT;
                end
            end
            ST_EOUT: begin
                n_state = i_status.emit_last ? ST_IDLE : ST_ERD;
            end
            ST_EMPTY: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands and result strobes.
    always_comb begin
        o_cmd         = '0;
        o_valid       = 1'b0;
        o_out_present = 1'b0;
        o_out_last    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = accept;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
            end
            ST_SRD: begin
                o_cmd.srch_rd = 1'b1;
            end
            ST_SCMP: begin
                o_cmd.hit    = i_status.cmp_eq && i_status.pat_end;
                o_cmd.next_j = i_status.cmp_eq && !i_status.pat_end;
                o_cmd.next_i = !i_status.cmp_eq && !i_status.last_pos;
            end
            ST_ERD: begin
                if (!i_status.emit_empty) begin
                    o_cmd.skip    = i_status.skip_here;
                    o_cmd.emit_rd = !i_status.skip_here;
                end
            end
            ST_EOUT: begin
                o_cmd.emit_out = 1'b1;
                o_cmd.finish   = i_status.emit_last;
                o_valid        = 1'b1;
                o_out_present  = 1'b1;
                o_out_last     = i_status.emit_last;
            end
            ST_EMPTY: begin
                o_cmd.finish    = 1'b1;
                o_cmd.out_empty = 1'b1;
                o_valid         = 1'b1;
                o_out_last      = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// ----- hdl/dfsm_dp.sv -----
// ----------------------------------------------------------------------------
// dfsm_dp
// Datapath: text and pattern memories, lengths, search and emit counters,
// and the flags carried on every result.
// ----------------------------------------------------------------------------
module dfsm_dp
    import dfsm_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic       i_req_type,
    input  logic [7:0] i_char_value,
    input  logic       i_char_present,
    input  logic       i_last_char,
    output t_dp_status o_status,
    output logic [7:0] o_out_char,
    output logic       o_match_found,
    output logic       o_overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    logic [7:0]    text_mem [MAX_LEN];
    logic [7:0]    pat_mem  [MAX_LEN];

    logic [LW-1:0] r_tlen;
    logic [LW-1:0] r_plen;
    logic          r_tclosed;
    logic          r_pclosed;
    logic          r_ovf;
    logic [LW-1:0] r_i;
    logic [LW-1:0] r_j;
    logic [LW-1:0] r_k;
    logic [LW-1:0] r_cnt;
    logic [LW-1:0] r_pos;
    logic          r_found;
    logic [7:0]    r_trd;
    logic [7:0]    r_prd;

    logic [LW-1:0] eff_len;
    logic          room;
    logic [LW-1:0] srch_addr;
    logic [AW-1:0] t_addr;
    logic [LW-1:0] n_res;
    logic [LW:0]   end_sum;

    // A closed string starts over from empty with its next word.
    always_comb begin
        if (i_req_type) begin
            eff_len = r_pclosed ? '0 : r_plen;
        end else begin
            eff_len = r_tclosed ? '0 : r_tlen;
        end
    end

    assign room      = (eff_len < LW'(MAX_LEN));
    assign srch_addr = r_i + r_j;
    assign t_addr    = i_cmd.emit_rd ? r_k[AW-1:0] : srch_addr[AW-1:0];
    assign n_res     = r_found ? (r_tlen - r_plen) : r_tlen;
    assign end_sum   = {1'b0, r_i} + {1'b0, r_plen} + (LW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_char_present && room) begin
            if (i_req_type) begin
                pat_mem[eff_len[AW-1:0]] <= i_char_value;
            end else begin
                text_mem[eff_len[AW-1:0]] <= i_char_value;
            end
        end
        if (i_cmd.srch_rd || i_cmd.emit_rd) begin
            r_trd <= text_mem[t_addr];
        end
        if (i_cmd.srch_rd) begin
            r_prd <= pat_mem[r_j[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlen    <= '0;
            r_plen    <= '0;
            r_tclosed <= 1'b1;
            r_pclosed <= 1'b1;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_req_type) begin
                    r_plen    <= (i_char_present && room) ? eff_len + LW'(1) : eff_len;
                    r_pclosed <= i_last_char;
                end else begin
                    r_tlen    <= (i_char_present && room) ? eff_len + LW'(1) : eff_len;
                    r_tclosed <= i_last_char;
                end
                if (i_char_present && !room) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_ovf     <= 1'b0;
                r_tclosed <= 1'b1;
                r_pclosed <= 1'b1;
            end
        end
    end

    // Search and emit counters; only meaningful while the controller is busy.
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.next_j) begin
            r_j <= r_j + LW'(1);
        end
        if (i_cmd.next_i) begin
            r_i <= r_i + LW'(1);
            r_j <= '0;
        end
        if (i_cmd.hit) begin
            r_found <= 1'b1;
            r_pos   <= r_i;
        end
        if (i_cmd.skip) begin
            r_k <= r_k + r_plen;
        end
        if (i_cmd.emit_rd) begin
            r_k <= r_k + LW'(1);
        end
        if (i_cmd.emit_out) begin
            r_cnt <= r_cnt + LW'(1);
        end
    end

    always_comb begin
        o_status.no_search  = (r_plen == '0) || (r_plen > r_tlen);
        o_status.cmp_eq     = (r_trd == r_prd);
        o_status.pat_end    = (r_j + LW'(1) == r_plen);
        o_status.last_pos   = (end_sum > {1'b0, r_tlen});
        o_status.emit_empty = (n_res == '0);
        o_status.skip_here  = r_found && (r_k == r_pos);
        o_status.emit_last  = (r_cnt + LW'(1) == n_res);
    end

    assign o_out_char    = i_cmd.out_empty ? 8'd0 : r_trd;
    assign o_match_found = r_found;
    assign o_overflow    = r_ovf;

endmodule

// ----- hdl/delete_first_substring_match.sv -----
// ----------------------------------------------------------------------------
// delete_first_substring_match
// Loads a text and a pattern as byte words, then delivers the text with the
// first occurrence of the pattern removed, one character per result word.
// ----------------------------------------------------------------------------
// Usage. A word is offered on i_req_type, i_char_value, i_char_present and
// i_last_char together with start; it is taken at a clock edge where start
// is high and busy is low. Text words (i_req_type low) and pattern words
// load at one word per cycle while busy is low, with no results. A word
// that ends the pattern raises busy and starts the search over the stored
// text. The search reads a character pair and then compares it, one pair
// at a time, restarting at the next text position on a mismatch.
// Emission then reads each result character from memory and outputs it,
// and jumps over the matched span in the read state. Each result word
// shows on o_valid for one cycle; the final one carries o_out_last, and
// busy falls the cycle after it. An empty result text gives a single
// word with o_out_present low. The receiver cannot stall: every strobed
// word is taken.
// Reset (synchronous, active low) empties both strings and clears the
// overflow flag; the character memories are not cleared.
// ----------------------------------------------------------------------------
module delete_first_substring_match
    import dfsm_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_req_type,
    input  logic [7:0] i_char_value,
    input  logic       i_char_present,
    input  logic       i_last_char,
    output logic       o_valid,
    output logic [7:0] o_out_char,
    output logic       o_out_present,
    output logic       o_out_last,
    output logic       o_match_found,
    output logic       o_overflow
);

    // Command and status words between the controller and the datapath.
    t_dp_cmd    cmd;
    t_dp_status status;

    // The controller owns the handshake and the result strobes.
    dfsm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_req_type    (i_req_type),
        .i_last_char   (i_last_char),
        .i_status      (status),
        .o_cmd         (cmd),
        .busy          (busy),
        .o_valid       (o_valid),
        .o_out_present (o_out_present),
        .o_out_last    (o_out_last)
    );

    // The datapath holds both strings and all counters of the search.
    dfsm_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_char_value   (i_char_value),
        .i_char_present (i_char_present),
        .i_last_char    (i_last_char),
        .o_status       (status),
        .o_out_char     (o_out_char),
        .o_match_found  (o_match_found),
        .o_overflow     (o_overflow)
    );

    // Results only appear while a search job is in progress.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result word outside a job");

    // The final result word ends the job.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_last) |=> !busy)
        else $error("job did not end after final word");

    // An empty result text is always a single, final word.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_present) |-> o_out_last)
        else $error("empty result word not final");

    // The match and overflow flags hold across all words of one result.
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_last) |=> ($stable(o_match_found) && $stable(o_overflow)))
        else $error("result flags changed within a job");

endmodule
